// File: hw/rtl/rom_image_checksum_defines.svh
// assertion macros for the rom image checksum block
// included by files that carry concurrent checks; no other dependencies
`ifndef ROM_IMAGE_CHECKSUM_DEFINES_SVH
`define ROM_IMAGE_CHECKSUM_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define RIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// condition must never hold
`define RIC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: check failed");

`else

`define RIC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RIC_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/ric_pkg.sv
// shared types and constants for the rom image checksum block
// no dependencies
package ric_pkg;

    localparam int WORD_W = 32;
    localparam int ROT_W  = 5;

    // seed loaded into all accumulators after reset
    localparam logic [WORD_W-1:0] SEED_RESET = 32'hF8CA4DDC;

    // one classified word as it travels from front to back
    typedef struct packed {
        logic [WORD_W-1:0] word;    // image word
        logic [WORD_W-1:0] rot;     // word rotated left by its own low bits
        logic              last;    // final word of the image
        logic              take;    // word is inside the covered length
        logic              ovf;     // some word of this image was dropped
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: hw/rtl/ric_fifo.sv
// small register queue between the front and back parts
// no package dependencies
module ric_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic              o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == FULL_CNT);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/ric_front.sv
// front part: takes image words, counts them against the covered length,
// rotates each word and marks drops; depends on ric_pkg
module ric_front #(
    parameter int TOTAL_WORDS = 262144
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [ric_pkg::WORD_W-1:0]       i_word,
    input  logic                             i_last,
    input  logic                             i_q_full,
    output logic                             o_ready,
    output logic                             o_push,
    output ric_pkg::t_entry                  o_entry,
    output logic [$clog2(TOTAL_WORDS+1)-1:0] o_missing
);

    localparam int CNT_W = $clog2(TOTAL_WORDS + 1);
    localparam logic [CNT_W-1:0] TOTAL_C = CNT_W'(TOTAL_WORDS);

    logic [CNT_W-1:0]           r_words;
    logic                       r_ovf;
    logic [CNT_W-1:0]           n_words;
    logic                       n_ovf;
    logic                       w_take;
    logic [ric_pkg::ROT_W-1:0]  w_amt;
    logic [2*ric_pkg::WORD_W-1:0] w_dbl;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;
    assign w_take  = (r_words < TOTAL_C);

    // rotate left by the low five bits; a zero amount leaves the word as is
    assign w_amt = i_word[ric_pkg::ROT_W-1:0];
    assign w_dbl = {i_word, i_word} << w_amt;

    always_comb begin
        o_entry.word = i_word;
        o_entry.rot  = w_dbl[2*ric_pkg::WORD_W-1:ric_pkg::WORD_W];
        o_entry.last = i_last;
        o_entry.take = w_take;
        o_entry.ovf  = r_ovf || !w_take;
        o_missing    = w_take ? (TOTAL_C - r_words - CNT_W'(1)) : '0;
    end

    // word count and drop flag for the current image
    always_comb begin
        n_words = r_words;
        n_ovf   = r_ovf;
        if (o_push) begin
            if (i_last) begin
                n_words = '0;
                n_ovf   = 1'b0;
            end else begin
                n_words = w_take ? r_words + CNT_W'(1) : r_words;
                n_ovf   = o_entry.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_words <= n_words;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// File: hw/rtl/ric_back.sv
// back part: folds words into the six accumulators, then pads and forms
// the two checksum words in a short pipeline; depends on ric_pkg
module ric_back #(
    parameter int TOTAL_WORDS = 262144
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ric_pkg::WORD_W-1:0]       i_seed,
    input  logic                             i_q_empty,
    input  ric_pkg::t_entry                  i_entry,
    input  logic [$clog2(TOTAL_WORDS+1)-1:0] i_missing,
    output logic                             o_pop,
    input  logic                             i_ready,
    output logic                             o_valid,
    output logic [ric_pkg::WORD_W-1:0]       o_first,
    output logic [ric_pkg::WORD_W-1:0]       o_second,
    output logic                             o_trunc
);

    localparam int CNT_W = $clog2(TOTAL_WORDS + 1);
    localparam int W     = ric_pkg::WORD_W;

    // accumulators
    logic [W-1:0] r_plain, r_carry, r_xor, r_rsum, r_sel, r_mix;
    logic [W-1:0] n_plain, n_carry, n_xor, n_rsum, n_sel, n_mix;
    logic [W:0]   w_sum;

    // finalize stage a
    logic             r_a_vld;
    logic [W-1:0]     r_a_first, r_a_rsum, r_a_sel, r_a_mix;
    logic [CNT_W-1:0] r_a_miss;
    logic             r_a_ovf;
    // finalize stage b
    logic             r_b_vld;
    logic [W-1:0]     r_b_first, r_b_rsx, r_b_mix, r_b_prod;
    logic             r_b_ovf;
    logic [W-1:0]     w_prod;
    // output register
    logic             r_o_vld;
    logic [W-1:0]     r_o_first, r_o_second;
    logic             r_o_ovf;

    logic w_out_en, w_b_en, w_a_en;

    // pipeline advance, from the output backward
    assign w_out_en = !r_o_vld || i_ready;
    assign w_b_en   = !r_b_vld || w_out_en;
    assign w_a_en   = !r_a_vld || w_b_en;
    assign o_pop    = !i_q_empty && (!i_entry.last || w_a_en);

    // per-word update of the accumulators
    always_comb begin
        w_sum   = {1'b0, r_plain} + {1'b0, i_entry.word};
        n_plain = r_plain;
        n_carry = r_carry;
        n_xor   = r_xor;
        n_rsum  = r_rsum;
        n_sel   = r_sel;
        n_mix   = r_mix;
        if (i_entry.take) begin
            n_plain = w_sum[W-1:0];
            n_carry = r_carry + W'(w_sum[W]);
            n_xor   = r_xor ^ i_entry.word;
            n_rsum  = r_rsum + i_entry.rot;
            n_sel   = r_sel ^ ((r_sel < i_entry.word) ? (w_sum[W-1:0] ^ i_entry.word)
                                                      : i_entry.rot);
            n_mix   = r_mix + (n_rsum ^ i_entry.word);
        end
    end

    // accumulator registers, re-seeded after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plain <= ric_pkg::SEED_RESET;
            r_carry <= ric_pkg::SEED_RESET;
            r_xor   <= ric_pkg::SEED_RESET;
            r_rsum  <= ric_pkg::SEED_RESET;
            r_sel   <= ric_pkg::SEED_RESET;
            r_mix   <= ric_pkg::SEED_RESET;
        end else if (o_pop) begin
            if (i_entry.last) begin
                r_plain <= i_seed;
                r_carry <= i_seed;
                r_xor   <= i_seed;
                r_rsum  <= i_seed;
                r_sel   <= i_seed;
                r_mix   <= i_seed;
            end else begin
                r_plain <= n_plain;
                r_carry <= n_carry;
                r_xor   <= n_xor;
                r_rsum  <= n_rsum;
                r_sel   <= n_sel;
                r_mix   <= n_mix;
            end
        end
    end

    // padding product: rotate sum times missing words, low word kept
    assign w_prod = r_a_rsum * W'(r_a_miss);

    // finalize valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_a_en) begin
                r_a_vld <= o_pop && i_entry.last;
            end
            if (w_b_en) begin
                r_b_vld <= r_a_vld;
            end
            if (w_out_en) begin
                r_o_vld <= r_b_vld;
            end
        end
    end

    // finalize payload
    always_ff @(posedge i_clk) begin
        if (w_a_en) begin
            r_a_first <= n_plain ^ n_carry ^ n_xor;
            r_a_rsum  <= n_rsum;
            r_a_sel   <= n_sel;
            r_a_mix   <= n_mix;
            r_a_miss  <= i_missing;
            r_a_ovf   <= i_entry.ovf;
        end
        if (w_b_en) begin
            r_b_first <= r_a_first;
            r_b_rsx   <= r_a_rsum ^ r_a_sel;
            r_b_mix   <= r_a_mix;
            r_b_prod  <= w_prod;
            r_b_ovf   <= r_a_ovf;
        end
        if (w_out_en) begin
            r_o_first  <= r_b_first;
            r_o_second <= r_b_rsx ^ (r_b_mix + r_b_prod);
            r_o_ovf    <= r_b_ovf;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_first  = r_o_first;
    assign o_second = r_o_second;
    assign o_trunc  = r_o_ovf;

endmodule

// File: hw/rtl/rom_image_checksum.sv
// Streaming image checksum: one 32-bit big-endian image word per request,
// the request with tlast closes the image and yields one result holding both
// checksum words and a truncation flag. The block sustains one word per
// clock unless the result stream stalls; the front counts and rotates
// each word, a queue of QUEUE_DEPTH entries decouples it from the
// accumulator update, which is one add chain per word. Images shorter
// than TOTAL_WORDS are padded with zero words by a multiply on the last
// word; words beyond TOTAL_WORDS are dropped and flagged. The seed
// register applies from the next image onward.
// top level; depends on ric_pkg, ric_front, ric_fifo, ric_back
`include "rom_image_checksum_defines.svh"

module rom_image_checksum #(
    parameter int TOTAL_WORDS = 262144,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: seed value
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,     // data_word
    input  logic        i_s_tlast,     // last_word
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,     // checksum_second, checksum_first
    output logic [0:0]  o_m_tuser      // truncated
);

    localparam int CNT_W = $clog2(TOTAL_WORDS + 1);
    localparam int Q_W   = ric_pkg::ENTRY_W + CNT_W;

    logic [ric_pkg::WORD_W-1:0] r_seed;
    logic                       w_push, w_pop, w_q_full, w_q_empty;
    ric_pkg::t_entry            w_f_entry, w_b_entry;
    logic [CNT_W-1:0]           w_f_miss, w_b_miss;
    logic [Q_W-1:0]             w_q_out;
    logic [ric_pkg::WORD_W-1:0] w_first, w_second;
    logic                       w_trunc;

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= ric_pkg::SEED_RESET;
        end else if (i_cfg_wr_en) begin
            r_seed <= i_cfg_wr_data;
        end
    end

    // front: count, rotate, classify
    ric_front #(
        .TOTAL_WORDS (TOTAL_WORDS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_word    (i_s_tdata),
        .i_last    (i_s_tlast),
        .i_q_full  (w_q_full),
        .o_ready   (o_s_tready),
        .o_push    (w_push),
        .o_entry   (w_f_entry),
        .o_missing (w_f_miss)
    );

    // queue between front and back
    ric_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_miss, w_f_entry}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    assign w_b_entry = w_q_out[ric_pkg::ENTRY_W-1:0];
    assign w_b_miss  = w_q_out[Q_W-1:ric_pkg::ENTRY_W];

    // back: accumulate and finalize
    ric_back #(
        .TOTAL_WORDS (TOTAL_WORDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed    (r_seed),
        .i_q_empty (w_q_empty),
        .i_entry   (w_b_entry),
        .i_missing (w_b_miss),
        .o_pop     (w_pop),
        .i_ready   (i_m_tready),
        .o_valid   (o_m_tvalid),
        .o_first   (w_first),
        .o_second  (w_second),
        .o_trunc   (w_trunc)
    );

    assign o_m_tdata = {w_second, w_first};
    assign o_m_tuser = w_trunc;

    // queue consistency across front and back
    `RIC_ASSERT_NEVER(a_q_full_empty, i_clk, i_rst_n, w_q_full && w_q_empty)
    `RIC_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n, w_push, !w_q_full)
    `RIC_ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_q_empty)

endmodule
